// File: rtl/core/fac_pkg.sv
// Shared constants and types for the frustum box culling unit.
package fac_pkg;

  localparam int PlaneCount  = 6;
  localparam int AxisCount   = 3;
  localparam int CellCount   = PlaneCount * AxisCount;
  localparam int PlaneBits   = 64;
  localparam int NormalBits  = 14;
  localparam int OffsetBits  = 22;
  localparam int OffsetLsb   = 42;
  localparam int OffsetShift = 12;
  localparam int CenterBits  = 24;
  localparam int ExtentBits  = 23;
  localparam int OpBits      = 25;
  localparam int ProdBits    = NormalBits + OpBits;
  localparam int AccBits     = 40;
  localparam int CfgIdxBits  = 3;

  typedef enum logic [CfgIdxBits-1:0] {
    IdxLeft   = 3'd0,
    IdxRight  = 3'd1,
    IdxTop    = 3'd2,
    IdxBottom = 3'd3,
    IdxNear   = 3'd4,
    IdxFar    = 3'd5
  } plane_idx_t;

  // One box on its way along the chain of cells.
  typedef struct packed {
    logic                                vis;
    logic [AccBits-1:0]                  acc;
    logic [AxisCount-1:0][OpBits-1:0]    sum;
    logic [AxisCount-1:0][OpBits-1:0]    diff;
  } token_t;

endpackage

// File: rtl/core/fac_if.sv
// Stream interfaces for box items and visibility results.
interface fac_box_if;
  import fac_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [CenterBits-1:0] center_x;
  logic signed [CenterBits-1:0] center_y;
  logic signed [CenterBits-1:0] center_z;
  logic [ExtentBits-1:0]        extent_x;
  logic [ExtentBits-1:0]        extent_y;
  logic [ExtentBits-1:0]        extent_z;

  modport source (output valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
                  input ready);
  modport sink (input valid, center_x, center_y, center_z, extent_x, extent_y, extent_z,
                output ready);
endinterface

interface fac_vis_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

// File: rtl/core/fac_entry.sv
// Entry stage: forms centre plus and minus extent for each axis.
module fac_entry (
  input  logic            clk,
  input  logic            rst,
  fac_box_if.sink         box,
  output logic            dn_valid,
  input  logic            dn_ready,
  output fac_pkg::token_t dn_tok
);
  import fac_pkg::*;

  logic   up_ready;
  token_t tok_next;
  logic [AxisCount-1:0][CenterBits-1:0] c;
  logic [AxisCount-1:0][ExtentBits-1:0] e;

  assign up_ready  = !dn_valid || dn_ready;
  assign box.ready = up_ready;

  assign c = {box.center_z, box.center_y, box.center_x};
  assign e = {box.extent_z, box.extent_y, box.extent_x};

  always_comb begin
    tok_next     = '0;
    tok_next.vis = 1'b1;
    // A positive seed lets the first plane cell apply its check unchanged.
    tok_next.acc = AccBits'(1);
    for (int k = 0; k < AxisCount; k++) begin
      tok_next.sum[k]  = OpBits'($signed({c[k][CenterBits-1], c[k]})
                                 + $signed({2'b00, e[k]}));
      tok_next.diff[k] = OpBits'($signed({c[k][CenterBits-1], c[k]})
                                 - $signed({2'b00, e[k]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= box.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && box.valid) begin
      dn_tok <= tok_next;
    end
  end

endmodule

// File: rtl/core/fac_cell.sv
// One cell of the chain: adds one axis term of one plane to the running sum.
module fac_cell #(
  parameter int AXIS = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [fac_pkg::PlaneBits-1:0]  plane,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  fac_pkg::token_t                up_tok,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output fac_pkg::token_t                dn_tok
);
  import fac_pkg::*;

  localparam int NormLsb = AXIS * NormalBits;

  logic signed [NormalBits-1:0] n;
  logic signed [OpBits-1:0]     op;
  logic signed [ProdBits-1:0]   prod;
  logic [OffsetBits-1:0]        d;
  logic [AccBits-1:0]           base;
  logic                         prev_keeps;
  token_t                       tok_next;

  assign up_ready = !dn_valid || dn_ready;

  assign n = $signed(plane[NormLsb +: NormalBits]);
  assign d = plane[OffsetLsb +: OffsetBits];

  // n*c + |n|*e equals n*(c+e) for a non-negative normal and n*(c-e) otherwise.
  assign op   = n[NormalBits-1] ? $signed(up_tok.diff[AXIS]) : $signed(up_tok.sum[AXIS]);
  assign prod = n * op;

  assign prev_keeps = !up_tok.acc[AccBits-1] && (up_tok.acc != '0);

  always_comb begin
    tok_next = up_tok;
    if (AXIS == 0) begin
      // The first axis of a plane closes the check of the plane before it.
      base         = {{(AccBits-OffsetBits-OffsetShift){d[OffsetBits-1]}}, d,
                      {OffsetShift{1'b0}}};
      tok_next.vis = up_tok.vis && prev_keeps;
    end else begin
      base = up_tok.acc;
    end
    tok_next.acc = base + {{(AccBits-ProdBits){prod[ProdBits-1]}}, prod};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_tok <= tok_next;
    end
  end

endmodule

// File: rtl/core/frustum_aabb_cull_unit.sv
// Top level of the frustum box culling unit: plane registers, cell chain, result register.
// Each box item is tested against six planes in a chain of eighteen cells, one cell per plane
// and axis, each with a single 14 by 25 bit multiplier. One item is taken every cycle while the
// output accepts results; each visible result is registered in the entry stage, the eighteen
// cells and the result register in turn; a stalled result register holds its item while the
// stages behind it keep filling. Plane registers reset to zero, so every box is culled until
// planes are written; writes to indices six and seven are ignored.
module frustum_aabb_cull_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wen,
  input  logic [fac_pkg::CfgIdxBits-1:0]   cfg_index,
  input  logic [fac_pkg::PlaneBits-1:0]    cfg_data,
  fac_box_if.sink                          box,
  fac_vis_if.source                        result
);
  import fac_pkg::*;

  localparam int OccBits = $clog2(CellCount + 3);

  logic [PlaneCount-1:0][PlaneBits-1:0] plane_reg;
  logic [CellCount:0]                   chain_valid;
  logic [CellCount:0]                   chain_ready;
  token_t                               chain_tok [CellCount+1];
  logic                                 last_keeps;
  logic [OccBits-1:0]                   occ;
  logic [OccBits-1:0]                   occ_next;
  logic                                 in_fire;
  logic                                 out_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_reg <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        IdxLeft:   plane_reg[0] <= cfg_data;
        IdxRight:  plane_reg[1] <= cfg_data;
        IdxTop:    plane_reg[2] <= cfg_data;
        IdxBottom: plane_reg[3] <= cfg_data;
        IdxNear:   plane_reg[4] <= cfg_data;
        IdxFar:    plane_reg[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  fac_entry u_entry (
    .clk      (clk),
    .rst      (rst),
    .box      (box),
    .dn_valid (chain_valid[0]),
    .dn_ready (chain_ready[0]),
    .dn_tok   (chain_tok[0])
  );

  for (genvar j = 0; j < CellCount; j++) begin : g_cell
    fac_cell #(
      .AXIS (j % AxisCount)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .plane    (plane_reg[j / AxisCount]),
      .up_valid (chain_valid[j]),
      .up_ready (chain_ready[j]),
      .up_tok   (chain_tok[j]),
      .dn_valid (chain_valid[j+1]),
      .dn_ready (chain_ready[j+1]),
      .dn_tok   (chain_tok[j+1])
    );
  end

  // The last plane's check is closed here, as the result is registered.
  assign last_keeps = !chain_tok[CellCount].acc[AccBits-1] && (chain_tok[CellCount].acc != '0);
  assign chain_ready[CellCount] = !result.valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (chain_ready[CellCount]) begin
      result.valid <= chain_valid[CellCount];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_ready[CellCount] && chain_valid[CellCount]) begin
      result.visible <= chain_tok[CellCount].vis && last_keeps;
    end
  end

  // Count of items inside the unit, kept for checking the stage valid bits.
  assign in_fire  = box.valid && box.ready;
  assign out_fire = result.valid && result.ready;

  always_comb begin
    occ_next = occ;
    if (in_fire && !out_fire) begin
      occ_next = occ + OccBits'(1);
    end else if (out_fire && !in_fire) begin
      occ_next = occ - OccBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else begin
      occ <= occ_next;
    end
  end

  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> chain_valid[0])
    else $error("accepted item did not reach the entry stage");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !box.ready |-> (&chain_valid) && result.valid && !result.ready)
    else $error("input stalled while the chain had a free stage");

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    int'(occ) == $countones({chain_valid, result.valid}))
    else $error("items lost or duplicated inside the chain");

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the frustum box culling unit.
`timescale 1ns / 1ps

module tb_top;
  import fac_pkg::*;

  localparam int ClockHalf   = 5;
  localparam int ResetCycles = 4;
  localparam int Latency     = 20;
  localparam int StallLimit  = 2000;
  localparam int PhaseCount  = 10;
  localparam int PhaseItems  = 130;

  localparam logic [CfgIdxBits-1:0] IdxSpareLow  = 3'd6;
  localparam logic [CfgIdxBits-1:0] IdxSpareHigh = 3'd7;

  localparam int NormalMax = (1 << (NormalBits - 1)) - 1;
  localparam int NormalMin = -(1 << (NormalBits - 1));
  localparam int OffsetMax = (1 << (OffsetBits - 1)) - 1;
  localparam int OffsetMin = -(1 << (OffsetBits - 1));
  localparam int CenterMax = (1 << (CenterBits - 1)) - 1;
  localparam int CenterMin = -(1 << (CenterBits - 1));
  localparam int ExtentMax = (1 << ExtentBits) - 1;
  localparam int UnitNormal = 1 << OffsetShift;

  typedef enum int {
    StyleFrustum,
    StyleSkewed,
    StyleRaw,
    StyleExtreme,
    StyleZero
  } plane_style_t;

  typedef struct packed {
    logic [CenterBits-1:0] cx;
    logic [CenterBits-1:0] cy;
    logic [CenterBits-1:0] cz;
    logic [ExtentBits-1:0] ex;
    logic [ExtentBits-1:0] ey;
    logic [ExtentBits-1:0] ez;
  } box_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CfgIdxBits-1:0] cfg_index;
  logic [PlaneBits-1:0]  cfg_data;

  fac_box_if box_ch ();
  fac_vis_if vis_ch ();

  frustum_aabb_cull_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box       (box_ch),
    .result    (vis_ch)
  );

  logic [PlaneBits-1:0] plane_q [PlaneCount];
  logic                 visible_due_q [$];
  int                   mismatch_count;
  int                   send_idle_pct;
  int                   recv_stall_pct;
  int                   quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #ClockHalf clk = ~clk;
  end

  // Largest plane value over the corners is n.c + d*2^12 + sum |n_i| e_i, kept exact.
  function automatic logic predict_visible(box_t b);
    longint                       pos [3];
    longint                       half [3];
    longint                       acc;
    longint                       n;
    logic signed [NormalBits-1:0] n_raw;
    logic signed [OffsetBits-1:0] d_raw;
    logic                         keep_all;
    pos[0]  = longint'($signed(b.cx));
    pos[1]  = longint'($signed(b.cy));
    pos[2]  = longint'($signed(b.cz));
    half[0] = longint'(b.ex);
    half[1] = longint'(b.ey);
    half[2] = longint'(b.ez);
    keep_all = 1'b1;
    for (int p = 0; p < PlaneCount; p++) begin
      d_raw = plane_q[p][OffsetLsb +: OffsetBits];
      acc   = d_raw;
      acc   = acc * UnitNormal;
      for (int a = 0; a < AxisCount; a++) begin
        n_raw = plane_q[p][a*NormalBits +: NormalBits];
        n     = n_raw;
        acc   = acc + n * pos[a] + ((n < 0) ? -n : n) * half[a];
      end
      if (acc <= 0) keep_all = 1'b0;
    end
    return keep_all;
  endfunction

  function automatic logic [PlaneBits-1:0] pack_plane(int nx, int ny, int nz, int od);
    return {od[OffsetBits-1:0], nz[NormalBits-1:0], ny[NormalBits-1:0], nx[NormalBits-1:0]};
  endfunction

  function automatic box_t make_box(int cx, int cy, int cz, int ex, int ey, int ez);
    box_t b;
    b.cx = cx[CenterBits-1:0];
    b.cy = cy[CenterBits-1:0];
    b.cz = cz[CenterBits-1:0];
    b.ex = ex[ExtentBits-1:0];
    b.ey = ey[ExtentBits-1:0];
    b.ez = ez[ExtentBits-1:0];
    return b;
  endfunction

  function automatic int pick_center();
    int r;
    r = $urandom_range(2);
    return (r == 0) ? CenterMin : ((r == 1) ? CenterMax : 0);
  endfunction

  function automatic int pick_extent();
    return $urandom_range(1) ? ExtentMax : 0;
  endfunction

  // Mostly boxes near the frustum with modest sizes, then raw bit patterns and corner values.
  function automatic box_t random_box();
    int   r;
    int   span;
    box_t b;
    r = $urandom_range(99);
    if (r < 70) begin
      span = ($urandom_range(3) == 0) ? (1 << 20) : (1 << 15);
      b = make_box($urandom_range(0, 1 << 21) - (1 << 20),
                   $urandom_range(0, 1 << 21) - (1 << 20),
                   $urandom_range(0, 1 << 21) - (1 << 20),
                   $urandom_range(0, span), $urandom_range(0, span),
                   $urandom_range(0, span));
    end else if (r < 90) begin
      b = make_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      b = make_box(pick_center(), pick_center(), pick_center(),
                   pick_extent(), pick_extent(), pick_extent());
    end
    return b;
  endfunction

  task automatic drain_results();
    @(negedge clk);
    box_ch.valid <= 1'b0;
    while (visible_due_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIdxBits-1:0] idx, input logic [PlaneBits-1:0] data);
    drain_results();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    if (idx < PlaneCount) plane_q[idx] = data;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic write_all_planes(input logic [PlaneBits-1:0] data);
    for (int p = 0; p < PlaneCount; p++) cfg_write(p[CfgIdxBits-1:0], data);
  endtask

  task automatic send_box(input box_t b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      box_ch.valid <= 1'b0;
      @(negedge clk);
    end
    box_ch.valid    <= 1'b1;
    box_ch.center_x <= b.cx;
    box_ch.center_y <= b.cy;
    box_ch.center_z <= b.cz;
    box_ch.extent_x <= b.ex;
    box_ch.extent_y <= b.ey;
    box_ch.extent_z <= b.ez;
    do @(posedge clk); while (!(box_ch.valid && box_ch.ready));
    visible_due_q.push_back(predict_visible(b));
  endtask

  task automatic set_planes(input plane_style_t style);
    int axis;
    int sgn;
    int nrm [3];
    int spread;
    int od;
    for (int p = 0; p < PlaneCount; p++) begin
      case (style)
        StyleFrustum, StyleSkewed: begin
          axis   = p / 2;
          sgn    = (p % 2 == 0) ? 1 : -1;
          spread = (style == StyleSkewed) ? 2048 : 512;
          for (int a = 0; a < AxisCount; a++)
            nrm[a] = $urandom_range(0, 2 * spread) - spread;
          nrm[axis] = sgn * ((style == StyleSkewed) ? $urandom_range(2048, NormalMax)
                                                    : $urandom_range(2048, 4095));
          od = $urandom_range(1 << 19, 1 << 20);
          cfg_write(p[CfgIdxBits-1:0], pack_plane(nrm[0], nrm[1], nrm[2], od));
        end
        StyleRaw: begin
          cfg_write(p[CfgIdxBits-1:0], {$urandom, $urandom});
        end
        StyleExtreme: begin
          for (int a = 0; a < AxisCount; a++)
            nrm[a] = $urandom_range(1) ? NormalMax : NormalMin;
          od = $urandom_range(1) ? OffsetMax : OffsetMin;
          cfg_write(p[CfgIdxBits-1:0], pack_plane(nrm[0], nrm[1], nrm[2], od));
        end
        default: begin
          cfg_write(p[CfgIdxBits-1:0], '0);
        end
      endcase
    end
  endtask

  // With every plane at zero, each plane value is zero and every box is culled.
  task automatic test_reset_planes();
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(CenterMin, CenterMin, CenterMin, ExtentMax, ExtentMax, ExtentMax));
    send_box(make_box(CenterMax, CenterMax, CenterMax, ExtentMax, ExtentMax, ExtentMax));
  endtask

  task automatic test_plane_boundaries();
    write_all_planes(pack_plane(0, 0, 0, 1));
    send_box(make_box(CenterMin, CenterMin, CenterMin, ExtentMax, ExtentMax, ExtentMax));
    send_box(make_box(CenterMax, CenterMax, CenterMax, 0, 0, 0));
    // A best corner lying exactly on the plane is culled; one step inside is kept.
    cfg_write(IdxLeft, pack_plane(UnitNormal, 0, 0, 0));
    send_box(make_box(-256, 0, 0, 256, 0, 0));
    send_box(make_box(-255, 0, 0, 256, 0, 0));
    send_box(make_box(CenterMin, 0, 0, ExtentMax, 0, 0));
    send_box(make_box(CenterMax, CenterMin, CenterMin, 0, 0, 0));
    cfg_write(IdxFar, pack_plane(0, 0, -UnitNormal, 256));
    send_box(make_box(256, 0, 512, 0, 0, 256));
    send_box(make_box(256, 0, 511, 0, 0, 256));
    write_all_planes(pack_plane(NormalMax, NormalMax, NormalMax, OffsetMax));
    send_box(make_box(CenterMin, CenterMin, CenterMin, 0, 0, 0));
    send_box(make_box(CenterMax, CenterMax, CenterMax, ExtentMax, ExtentMax, ExtentMax));
    write_all_planes(pack_plane(NormalMin, NormalMin, NormalMin, OffsetMin));
    send_box(make_box(CenterMin, CenterMin, CenterMin, ExtentMax, ExtentMax, ExtentMax));
    send_box(make_box(CenterMax, CenterMax, CenterMax, 0, 0, 0));
    send_box(make_box(0, 0, 0, 0, 0, 0));
  endtask

  // Writes beyond the last plane must leave all planes untouched.
  task automatic test_unused_index();
    write_all_planes(pack_plane(0, 0, 0, 1));
    cfg_write(IdxSpareLow, '0);
    cfg_write(IdxSpareHigh, '0);
    send_box(make_box(0, 0, 0, 0, 0, 0));
    send_box(make_box(CenterMax, CenterMin, 0, ExtentMax, 0, ExtentMax));
  endtask

  task automatic test_random_boxes();
    for (int ph = 0; ph < PhaseCount; ph++) begin
      set_planes(plane_style_t'(ph % 5));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      for (int i = 0; i < PhaseItems; i++) begin
        // Now and then the sender holds off until the pipeline has emptied.
        if (ph % 3 == 0 && i == PhaseItems / 2) drain_results();
        send_box(random_box());
      end
    end
  endtask

  always @(negedge clk) begin
    vis_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (vis_ch.valid && vis_ch.ready) begin
      if (visible_due_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual visible %0b",
                 $time, vis_ch.visible);
        mismatch_count++;
      end else if (vis_ch.visible !== visible_due_q[0]) begin
        $display("%0t: visible mismatch, expected %0b, actual %0b",
                 $time, visible_due_q[0], vis_ch.visible);
        mismatch_count++;
        void'(visible_due_q.pop_front());
      end else begin
        void'(visible_due_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (box_ch.valid && box_ch.ready) || (vis_ch.valid && vis_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_wen         = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    box_ch.valid    = 1'b0;
    box_ch.center_x = '0;
    box_ch.center_y = '0;
    box_ch.center_z = '0;
    box_ch.extent_x = '0;
    box_ch.extent_y = '0;
    box_ch.extent_z = '0;
    vis_ch.ready    = 1'b0;
    mismatch_count  = 0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    quiet_cycles    = 0;
    for (int p = 0; p < PlaneCount; p++) plane_q[p] = '0;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_planes();
    test_plane_boundaries();
    test_unused_index();
    test_random_boxes();

    drain_results();
    repeat (2 * Latency) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// File: frustum_aabb_cull_unit.f
rtl/core/fac_pkg.sv
rtl/core/fac_if.sv
rtl/core/fac_entry.sv
rtl/core/fac_cell.sv
rtl/core/frustum_aabb_cull_unit.sv
tb/tb_top.sv
